// File: rtl/core/u8xml_pkg.sv
// shared types, status codes and xml name range tables for the utf-8 decoder
// used by u8xml_decode, u8xml_class and utf8_decode_xml_name_class
// no dependencies
package u8xml_pkg;

  localparam int CP_W = 21;

  typedef logic [CP_W-1:0] cp_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_CONT = 3'd1,
    ST_OVERLONG = 3'd2,
    ST_STRAY    = 3'd3,
    ST_ILLEGAL  = 3'd4
  } status_t;

  // one decode step outcome
  typedef struct packed {
    logic    emit;
    cp_t     code_point;
    status_t status;
  } dec_result_t;

  // smallest legal value by sequence length minus one
  function automatic cp_t min_value(input logic [1:0] seq_len);
    cp_t v;
    case (seq_len)
      2'd0:    v = cp_t'(21'h0);
      2'd1:    v = cp_t'(21'h80);
      2'd2:    v = cp_t'(21'h800);
      default: v = cp_t'(21'h10000);
    endcase
    return v;
  endfunction

  // half-open ranges [lo, hi) of name start characters
  localparam int NUM_START = 16;
  localparam cp_t START_LO [NUM_START] = '{
    21'h3a,   21'h41,   21'h5f,   21'h61,
    21'hc0,   21'hd8,   21'hf8,   21'h370,
    21'h37f,  21'h200c, 21'h2070, 21'h2c00,
    21'h3001, 21'hf900, 21'hfdf0, 21'h10000
  };
  localparam cp_t START_HI [NUM_START] = '{
    21'h3b,   21'h5b,   21'h60,   21'h7b,
    21'hd7,   21'hf7,   21'h300,  21'h37e,
    21'h2000, 21'h200e, 21'h2190, 21'h2ff0,
    21'hd800, 21'hfdd0, 21'hfffe, 21'hf0000
  };

  // half-open ranges [lo, hi) of name characters
  localparam int NUM_NAME = 18;
  localparam cp_t NAME_LO [NUM_NAME] = '{
    21'h2d,   21'h30,   21'h41,   21'h5f,
    21'h61,   21'hb7,   21'hc0,   21'hd8,
    21'hf8,   21'h37f,  21'h200c, 21'h203f,
    21'h2070, 21'h2c00, 21'h3001, 21'hf900,
    21'hfdf0, 21'h10000
  };
  localparam cp_t NAME_HI [NUM_NAME] = '{
    21'h2f,   21'h3b,   21'h5b,   21'h60,
    21'h7b,   21'hb8,   21'hd7,   21'hf7,
    21'h37e,  21'h2000, 21'h200e, 21'h2041,
    21'h2190, 21'h2ff0, 21'hd800, 21'hfdd0,
    21'hfffe, 21'hf0000
  };

endpackage

// File: rtl/core/u8xml_decode.sv
// utf-8 sequence assembly: partial code point, continuation count, error checks
// depends on u8xml_pkg
module u8xml_decode (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [7:0]               data_byte,
  output u8xml_pkg::dec_result_t   result
);

  u8xml_pkg::cp_t partial_value, partial_value_next;
  logic [1:0]     bytes_remaining, bytes_remaining_next;
  logic [1:0]     sequence_length, sequence_length_next;
  u8xml_pkg::cp_t assembled;

  // shift in six payload bits, top bits fall off
  assign assembled = {partial_value[u8xml_pkg::CP_W-7:0], data_byte[5:0]};

  always_comb begin
    partial_value_next   = partial_value;
    bytes_remaining_next = bytes_remaining;
    sequence_length_next = sequence_length;
    result.emit          = 1'b0;
    result.code_point    = '0;
    result.status        = u8xml_pkg::ST_OK;
    if (bytes_remaining == 2'd0) begin
      if (data_byte inside {[8'h00:8'h7f]}) begin
        result.emit       = 1'b1;
        result.code_point = u8xml_pkg::cp_t'(data_byte);
      end else if (data_byte inside {[8'h80:8'hbf]}) begin
        result.emit   = 1'b1;
        result.status = u8xml_pkg::ST_STRAY;
      end else if (data_byte inside {[8'hc2:8'hdf]}) begin
        partial_value_next   = u8xml_pkg::cp_t'(data_byte[4:0]);
        bytes_remaining_next = 2'd1;
        sequence_length_next = 2'd1;
      end else if (data_byte inside {[8'he0:8'hef]}) begin
        partial_value_next   = u8xml_pkg::cp_t'(data_byte[3:0]);
        bytes_remaining_next = 2'd2;
        sequence_length_next = 2'd2;
      end else if (data_byte inside {[8'hf0:8'hf4]}) begin
        partial_value_next   = u8xml_pkg::cp_t'(data_byte[2:0]);
        bytes_remaining_next = 2'd3;
        sequence_length_next = 2'd3;
      end else begin
        result.emit   = 1'b1;
        result.status = u8xml_pkg::ST_ILLEGAL;
      end
    end else if (data_byte[7:6] != 2'b10) begin
      // byte is consumed, not restarted as a lead
      result.emit          = 1'b1;
      result.status        = u8xml_pkg::ST_BAD_CONT;
      partial_value_next   = '0;
      bytes_remaining_next = 2'd0;
      sequence_length_next = 2'd0;
    end else if (bytes_remaining == 2'd1) begin
      result.emit          = 1'b1;
      partial_value_next   = '0;
      bytes_remaining_next = 2'd0;
      sequence_length_next = 2'd0;
      if (assembled < u8xml_pkg::min_value(sequence_length)) begin
        result.status = u8xml_pkg::ST_OVERLONG;
      end else begin
        result.code_point = assembled;
      end
    end else begin
      partial_value_next   = assembled;
      bytes_remaining_next = bytes_remaining - 2'd1;
    end
    if (!step) begin
      result.emit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      bytes_remaining <= 2'd0;
      sequence_length <= 2'd0;
    end else if (step) begin
      partial_value   <= partial_value_next;
      bytes_remaining <= bytes_remaining_next;
      sequence_length <= sequence_length_next;
    end
  end

endmodule

// File: rtl/core/u8xml_class.sv
// xml NameStartChar / NameChar classification by parallel range compares
// depends on u8xml_pkg range tables
module u8xml_class (
  input  u8xml_pkg::cp_t code_point,
  input  logic           ok,
  output logic           name_start,
  output logic           name_char
);

  logic [u8xml_pkg::NUM_START-1:0] start_hit;
  logic [u8xml_pkg::NUM_NAME-1:0]  name_hit;

  always_comb begin
    for (int i = 0; i < u8xml_pkg::NUM_START; i++) begin
      start_hit[i] = (code_point >= u8xml_pkg::START_LO[i]) &&
                     (code_point <  u8xml_pkg::START_HI[i]);
    end
    for (int i = 0; i < u8xml_pkg::NUM_NAME; i++) begin
      name_hit[i] = (code_point >= u8xml_pkg::NAME_LO[i]) &&
                    (code_point <  u8xml_pkg::NAME_HI[i]);
    end
  end

  assign name_start = ok && (|start_hit);
  assign name_char  = ok && (|name_hit);

endmodule

// File: rtl/core/utf8_decode_xml_name_class.sv
// top level: streaming utf-8 decoder with xml name character flags
// depends on u8xml_pkg, u8xml_decode, u8xml_class
//
// One byte of a utf-8 stream enters per slave transfer, and one result
// leaves per finished character or per malformed byte; leads and good
// non-final continuation bytes produce nothing. Each byte sits in the
// input register, goes through the sequence check and the range compares,
// and lands in the result register, so the block sustains one byte per
// cycle while the result side is not stalled.
// The result register is the only thing that can stall the input side;
// a new byte is still taken while a finished result waits for m_tready, as
// long as the input register is empty. Errors (stray or bad continuation,
// overlong form, illegal lead) report code point zero with both flags low
// and return the decoder to idle after consuming the offending byte.
// Surrogates and values up to 0x13ffff pass as ok.
module utf8_decode_xml_name_class (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic [4:0]  m_tuser    // [2:0] status, [3] name_start, [4] name_char
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // result register
  logic                out_valid;
  u8xml_pkg::cp_t      out_code_point;
  u8xml_pkg::status_t  out_status;
  logic                out_name_start;
  logic                out_name_char;

  logic                   advance;
  logic                   step;
  u8xml_pkg::dec_result_t dec_res;
  logic                   cls_start;
  logic                   cls_char;

  // result slot free, so the byte in the input register may be processed
  assign advance  = !out_valid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  u8xml_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_byte),
    .result    (dec_res)
  );

  u8xml_class u_class (
    .code_point (dec_res.code_point),
    .ok         (dec_res.status == u8xml_pkg::ST_OK),
    .name_start (cls_start),
    .name_char  (cls_char)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && dec_res.emit;
    end
  end

  // payload only loads on a real result
  always_ff @(posedge clk) begin
    if (advance && dec_res.emit) begin
      out_code_point <= dec_res.code_point;
      out_status     <= dec_res.status;
      out_name_start <= cls_start;
      out_name_char  <= cls_char;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_code_point};
  assign m_tuser  = {out_name_char, out_name_start, out_status};

endmodule

// File: verif/utf8_xml_class_checker.sv
// checker for the utf-8 decoder with xml name flags: predicts every result
// from the accepted input bytes and compares the result channel against it
// depends on u8xml_pkg for the code point type and the status codes
module utf8_xml_class_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic [4:0]  m_tuser,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    u8xml_pkg::cp_t     code_point;
    u8xml_pkg::status_t status;
    logic               name_start;
    logic               name_char;
  } char_result_t;

  char_result_t char_q[$];

  // decoder state as the predictor sees it
  u8xml_pkg::cp_t partial_cp;
  logic [1:0]     conts_left;
  logic [1:0]     seq_len;

  function automatic bit is_name_start(u8xml_pkg::cp_t c);
    return (c == 21'h3a) || (c >= 21'h41 && c < 21'h5b) || (c == 21'h5f) ||
           (c >= 21'h61 && c < 21'h7b) || (c >= 21'hc0 && c < 21'hd7) ||
           (c >= 21'hd8 && c < 21'hf7) || (c >= 21'hf8 && c < 21'h300) ||
           (c >= 21'h370 && c < 21'h37e) || (c >= 21'h37f && c < 21'h2000) ||
           (c >= 21'h200c && c < 21'h200e) || (c >= 21'h2070 && c < 21'h2190) ||
           (c >= 21'h2c00 && c < 21'h2ff0) || (c >= 21'h3001 && c < 21'hd800) ||
           (c >= 21'hf900 && c < 21'hfdd0) || (c >= 21'hfdf0 && c < 21'hfffe) ||
           (c >= 21'h10000 && c < 21'hf0000);
  endfunction

  // name chars are the start set plus digits, hyphen, dot, middle dot,
  // combining marks and the two undertie characters
  function automatic bit is_name_char(u8xml_pkg::cp_t c);
    return is_name_start(c) || (c >= 21'h2d && c < 21'h2f) ||
           (c >= 21'h30 && c < 21'h3a) || (c == 21'hb7) ||
           (c >= 21'h300 && c < 21'h370) || (c >= 21'h203f && c < 21'h2041);
  endfunction

  function automatic char_result_t make_result(u8xml_pkg::cp_t c,
                                               u8xml_pkg::status_t st);
    char_result_t r;
    r = '0;
    r.status = st;
    if (st == u8xml_pkg::ST_OK) begin
      r.code_point = c;
      r.name_start = is_name_start(c);
      r.name_char  = is_name_char(c);
    end
    return r;
  endfunction

  // one byte through the decoder; returns 1 when a result comes out
  function automatic bit decode_byte(input logic [7:0] b, output char_result_t r);
    u8xml_pkg::cp_t full_cp;
    u8xml_pkg::cp_t lowest;
    r = '0;
    if (conts_left == 2'd0) begin
      if (b < 8'h80) begin
        r = make_result(u8xml_pkg::cp_t'(b), u8xml_pkg::ST_OK);
        return 1'b1;
      end
      if (b[7:6] == 2'b10) begin
        r = make_result('0, u8xml_pkg::ST_STRAY);
        return 1'b1;
      end
      if (b >= 8'hc2 && b <= 8'hdf) begin
        partial_cp = u8xml_pkg::cp_t'(b[4:0]);
        conts_left = 2'd1;
        seq_len    = 2'd1;
        return 1'b0;
      end
      if (b >= 8'he0 && b <= 8'hef) begin
        partial_cp = u8xml_pkg::cp_t'(b[3:0]);
        conts_left = 2'd2;
        seq_len    = 2'd2;
        return 1'b0;
      end
      if (b >= 8'hf0 && b <= 8'hf4) begin
        partial_cp = u8xml_pkg::cp_t'(b[2:0]);
        conts_left = 2'd3;
        seq_len    = 2'd3;
        return 1'b0;
      end
      r = make_result('0, u8xml_pkg::ST_ILLEGAL);
      return 1'b1;
    end
    if (b[7:6] != 2'b10) begin
      partial_cp = '0;
      conts_left = 2'd0;
      seq_len    = 2'd0;
      r = make_result('0, u8xml_pkg::ST_BAD_CONT);
      return 1'b1;
    end
    partial_cp = {partial_cp[14:0], b[5:0]};
    conts_left = conts_left - 2'd1;
    if (conts_left != 2'd0)
      return 1'b0;
    case (seq_len)
      2'd1:    lowest = 21'h80;
      2'd2:    lowest = 21'h800;
      2'd3:    lowest = 21'h10000;
      default: lowest = 21'h0;
    endcase
    full_cp    = partial_cp;
    partial_cp = '0;
    seq_len    = 2'd0;
    if (full_cp < lowest)
      r = make_result('0, u8xml_pkg::ST_OVERLONG);
    else
      r = make_result(full_cp, u8xml_pkg::ST_OK);
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 40)
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
    partial_cp  = '0;
    conts_left  = 2'd0;
    seq_len     = 2'd0;
  end

  always @(posedge clk) begin
    char_result_t want;
    if (rst) begin
      partial_cp = '0;
      conts_left = 2'd0;
      seq_len    = 2'd0;
      char_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        if (decode_byte(s_tdata, want))
          char_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (char_q.size() == 0) begin
          report_mismatch("unexpected result, code point", int'(m_tdata[20:0]), 0);
        end else begin
          want = char_q.pop_front();
          if (m_tdata[20:0] != want.code_point)
            report_mismatch("code point", int'(m_tdata[20:0]), int'(want.code_point));
          if (m_tuser[2:0] != want.status)
            report_mismatch("status", int'(m_tuser[2:0]), int'(want.status));
          if (m_tuser[3] != want.name_start)
            report_mismatch("name start flag", int'(m_tuser[3]), int'(want.name_start));
          if (m_tuser[4] != want.name_char)
            report_mismatch("name char flag", int'(m_tuser[4]), int'(want.name_char));
        end
      end
    end
    outstanding = char_q.size();
  end

endmodule

// File: verif/utf8_decode_xml_name_class_tb.sv
// testbench top for utf8_decode_xml_name_class: drives utf-8 byte streams,
// random stalls on both channels and gives the verdict
// depends on u8xml_pkg, the rtl under rtl/core and utf8_xml_class_checker
module utf8_decode_xml_name_class_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // [20:0] code_point, [23:21] zero
  logic [4:0]  m_tuser;           // [2:0] status, [3] name_start, [4] name_char

  int mismatches;
  int outstanding;

  // once set, neither side idles any more
  bit quiet_tail = 1'b0;

  // bytes waiting to be sent
  logic [7:0] byte_q[$];

  // edges of the xml name tables, used as code point targets
  localparam int NUM_EDGES = 39;
  localparam int unsigned TABLE_EDGES [NUM_EDGES] = '{
    'h2d, 'h2f, 'h30, 'h3a, 'h3b, 'h41, 'h5b, 'h5f, 'h60, 'h61,
    'h7b, 'hb7, 'hb8, 'hc0, 'hd7, 'hd8, 'hf7, 'hf8, 'h300, 'h370,
    'h37e, 'h37f, 'h2000, 'h200c, 'h200e, 'h203f, 'h2041, 'h2070, 'h2190, 'h2c00,
    'h2ff0, 'h3001, 'hd800, 'hf900, 'hfdd0, 'hfdf0, 'hfffe, 'h10000, 'hf0000
  };

  always #5 clk = ~clk;

  utf8_decode_xml_name_class DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  utf8_xml_class_checker char_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // utf-8 encoding of a code point in a given number of bytes; a length
  // longer than needed gives an overlong form, a value past 0x13ffff in
  // four bytes gives an illegal lead
  task automatic add_char(input int unsigned cp, input int len);
    logic [20:0] v;
    v = cp[20:0];
    case (len)
      1: byte_q.push_back({1'b0, v[6:0]});
      2: begin
        byte_q.push_back({3'b110, v[10:6]});
        byte_q.push_back({2'b10, v[5:0]});
      end
      3: begin
        byte_q.push_back({4'b1110, v[15:12]});
        byte_q.push_back({2'b10, v[11:6]});
        byte_q.push_back({2'b10, v[5:0]});
      end
      default: begin
        byte_q.push_back({5'b11110, v[20:18]});
        byte_q.push_back({2'b10, v[17:12]});
        byte_q.push_back({2'b10, v[11:6]});
        byte_q.push_back({2'b10, v[5:0]});
      end
    endcase
  endtask

  // random traffic: mostly well-formed characters of every length, table
  // edges, overlong forms, cut-off sequences and raw noise
  task automatic add_random_traffic(input int target);
    int unsigned kind;
    int unsigned cp;
    int len;
    int cut;
    logic [7:0] lead_bytes[$];
    while (byte_q.size() < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        add_char($urandom_range(0, 'h7f), 1);
      end else if (kind < 42) begin
        // right at a range edge or one below it
        cp = TABLE_EDGES[$urandom_range(0, NUM_EDGES - 1)] - $urandom_range(0, 1);
        len = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
        add_char(cp, len);
      end else if (kind < 54) begin
        add_char($urandom_range('h80, 'h7ff), 2);
      end else if (kind < 66) begin
        // includes the surrogate block, which passes as ok
        add_char($urandom_range('h800, 'hffff), 3);
      end else if (kind < 76) begin
        add_char($urandom_range('h10000, 'h13ffff), 4);
      end else if (kind < 82) begin
        // overlong: more bytes than needed
        len = $urandom_range(2, 4);
        cp = (len == 2) ? $urandom_range(0, 'h7f) :
             (len == 3) ? $urandom_range(0, 'h7ff) : $urandom_range(0, 'hffff);
        add_char(cp, len);
      end else if (kind < 92) begin
        // sequence broken by a byte that is not a continuation
        len = $urandom_range(2, 4);
        cp = (len == 2) ? $urandom_range('h80, 'h7ff) :
             (len == 3) ? $urandom_range('h800, 'hffff) : $urandom_range('h10000, 'h10ffff);
        add_char(cp, len);
        cut = $urandom_range(1, len - 1);
        repeat (len - cut) lead_bytes.push_back(byte_q.pop_back());
        lead_bytes.delete();
        if ($urandom_range(0, 1))
          byte_q.push_back(8'($urandom_range(0, 'h7f)));
        else
          byte_q.push_back(8'($urandom_range('hc0, 'hff)));
      end else begin
        byte_q.push_back(8'($urandom));
      end
    end
  endtask

  // one byte over the slave channel; entered and left at a falling edge
  task automatic push_byte(input logic [7:0] b);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  // hold the sender until every predicted result has come out, then let
  // the pipeline settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // result side stalls in random bursts, never in the quiet tail
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (quiet_tail || stall == 0) begin
        m_tready <= 1'b1;
        if (!quiet_tail && $urandom_range(0, 7) == 0)
          stall = $urandom_range(1, 11);
      end else begin
        m_tready <= 1'b0;
        stall--;
      end
    end
  end

  // hard stop if the run hangs
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int total;
    int guard;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: ascii extremes, stray and illegal bytes, both ends of the
    // two-byte range, an overlong and the longest three-byte form, both ends
    // of the four-byte range and a sequence broken by an ascii byte
    byte_q = '{8'h00, 8'h7f, 8'h80, 8'hbf, 8'hc0, 8'hc1, 8'hf5, 8'hff};
    add_char('h80, 2);
    add_char('h7ff, 2);
    add_char('h7ff, 3);
    add_char('hffff, 3);
    add_char('h10000, 4);
    add_char('h13ffff, 4);
    byte_q.push_back(8'hc2);
    byte_q.push_back(8'h41);
    while (byte_q.size() != 0) push_byte(byte_q.pop_front());
    drain_results();

    // random part, pausing for the results now and then
    add_random_traffic(1200);
    total = byte_q.size();
    for (int i = 0; i < total; i++) begin
      if (i == (total * 85) / 100)
        quiet_tail = 1'b1;
      if (i == 300 || i == 700)
        drain_results();
      push_byte(byte_q.pop_front());
    end
    s_tvalid <= 1'b0;

    guard = 0;
    while (outstanding != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (10) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
